FILE: rtl/assert_macros.svh
// assertion macros shared by the semaphore rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// plain property checked on every clock edge outside reset
`define CSQ_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("csq assertion failed");

// implication: when ante holds, cons holds in the same cycle
`define CSQ_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("csq assertion failed");

// implication: when ante holds, cons holds in the next cycle
`define CSQ_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("csq assertion failed");

`endif

FILE: rtl/csq_pkg.sv
// types and constants of the counting semaphore wait queue
package csq_pkg;

  localparam int unsigned QUEUE_DEPTH_DEF = 16;
  localparam int unsigned COUNT_W         = 18;
  localparam int unsigned CFG_W           = 16;
  localparam int unsigned TID_W           = 8;

  localparam logic [COUNT_W-1:0] COUNT_MAX = 18'h1FFFF;

  // action codes
  localparam logic [1:0] ACT_WAIT   = 2'd0;
  localparam logic [1:0] ACT_SIGNAL = 2'd1;
  localparam logic [1:0] ACT_CLOSE  = 2'd2;

  // status codes
  localparam logic [1:0] STAT_OK     = 2'd0;
  localparam logic [1:0] STAT_CLOSED = 2'd1;
  localparam logic [1:0] STAT_FULL   = 2'd2;

  // outcome codes
  localparam logic [1:0] OUT_PROCEED  = 2'd0;
  localparam logic [1:0] OUT_BLOCKED  = 2'd1;
  localparam logic [1:0] OUT_RELEASED = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_DRAIN
  } csq_state_e;

  typedef struct packed {
    logic [1:0]       action;
    logic [TID_W-1:0] caller_id;
  } csq_in_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [1:0]       outcome;
    logic [TID_W-1:0] thread_id;
    logic             last;
  } csq_out_t;

  // result handed from the core to the output register
  typedef struct packed {
    logic     valid;
    csq_out_t data;
  } csq_res_t;

endpackage

FILE: rtl/csq_ram.sv
// generic single-write single-read ram with registered read data
module csq_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/csq_core.sv
// semaphore sequencer: count, queue pointers and wait queue ram
`include "assert_macros.svh"

module csq_core #(
  parameter int unsigned QUEUE_DEPTH = csq_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  csq_pkg::csq_in_t          in_data_i,
  input  logic                      out_free_i,
  output csq_pkg::csq_res_t         res_o,
  input  logic                      cfg_we_i,
  input  logic [csq_pkg::CFG_W-1:0] cfg_wdata_i
);
  import csq_pkg::*;

  localparam int unsigned QIW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned FW  = $clog2(QUEUE_DEPTH + 1);
  localparam logic [QIW-1:0] LAST_IDX = QIW'(QUEUE_DEPTH - 1);
  localparam logic [FW-1:0]  FULL_FILL = FW'(QUEUE_DEPTH);
  localparam logic [FW-1:0]  ONE_FILL  = FW'(1);

  csq_state_e state_q, state_d;
  logic [1:0]         action_q, action_d;
  logic [TID_W-1:0]   caller_q, caller_d;
  logic [COUNT_W-1:0] count_q, count_d;
  logic               open_q, open_d;
  logic [QIW-1:0]     head_q, head_d;
  logic [QIW-1:0]     tail_q, tail_d;
  logic [FW-1:0]      fill_q, fill_d;

  logic               ram_we;
  logic               ram_re;
  logic [QIW-1:0]     ram_raddr;
  logic [TID_W-1:0]   ram_rdata;

  logic [QIW-1:0]     head_nx;
  logic [QIW-1:0]     tail_nx;
  logic [COUNT_W-1:0] count_inc;
  logic [COUNT_W-1:0] count_dec;
  logic               count_le0;
  logic               inc_le0;
  logic               drain_more;

  csq_res_t res;

  assign head_nx   = (head_q == LAST_IDX) ? '0 : head_q + 1'b1;
  assign tail_nx   = (tail_q == LAST_IDX) ? '0 : tail_q + 1'b1;
  assign count_inc = count_q + 1'b1;
  assign count_dec = count_q - 1'b1;
  assign count_le0 = count_q[COUNT_W-1] || (count_q == '0);
  assign inc_le0   = count_inc[COUNT_W-1] || (count_inc == '0);
  // a close still has waiters after the one released this cycle
  assign drain_more = (fill_q > ONE_FILL);

  csq_ram #(
    .WIDTH(TID_W),
    .DEPTH(QUEUE_DEPTH)
  ) u_queue_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(tail_q),
    .wdata_i(caller_q),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (out_free_i) begin
          if (action_q == ACT_CLOSE && open_q && drain_more) begin
            state_d = ST_DRAIN;
          end else begin
            state_d = ST_IDLE;
          end
        end
      end
      ST_DRAIN: begin
        if (out_free_i && !drain_more) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // datapath and results
  always_comb begin
    action_d  = action_q;
    caller_d  = caller_q;
    count_d   = count_q;
    open_d    = open_q;
    head_d    = head_q;
    tail_d    = tail_q;
    fill_d    = fill_q;
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    ram_raddr = head_q;
    res       = '0;
    res.data.last = 1'b1;
    in_ready_o = (state_q == ST_IDLE);

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          // fetch the oldest waiter in case this is a signal or close
          ram_re   = 1'b1;
          action_d = in_data_i.action;
          caller_d = in_data_i.caller_id;
        end
      end
      ST_EXEC: begin
        if (out_free_i) begin
          res.valid = 1'b1;
          if (action_q != ACT_WAIT && action_q != ACT_SIGNAL && action_q != ACT_CLOSE) begin
            res.data.status = STAT_OK;
          end else if (!open_q) begin
            res.data.status = STAT_CLOSED;
          end else begin
            unique case (action_q)
              ACT_WAIT: begin
                if (count_le0) begin
                  if (fill_q == FULL_FILL) begin
                    res.data.status = STAT_FULL;
                  end else begin
                    count_d = count_dec;
                    ram_we  = 1'b1;
                    tail_d  = tail_nx;
                    fill_d  = fill_q + 1'b1;
                    res.data.outcome   = OUT_BLOCKED;
                    res.data.thread_id = caller_q;
                  end
                end else begin
                  count_d = count_dec;
                end
              end
              ACT_SIGNAL: begin
                if (!count_q[COUNT_W-1] && count_q >= COUNT_MAX) begin
                  count_d = COUNT_MAX;
                end else begin
                  count_d = count_inc;
                  if (inc_le0 && fill_q != '0) begin
                    head_d = head_nx;
                    fill_d = fill_q - 1'b1;
                    res.data.outcome   = OUT_RELEASED;
                    res.data.thread_id = ram_rdata;
                  end
                end
              end
              ACT_CLOSE: begin
                open_d = 1'b0;
                if (fill_q != '0) begin
                  fill_d = fill_q - 1'b1;
                  res.data.outcome   = OUT_RELEASED;
                  res.data.thread_id = ram_rdata;
                  res.data.last      = !drain_more;
                  if (drain_more) begin
                    head_d    = head_nx;
                    ram_re    = 1'b1;
                    ram_raddr = head_nx;
                  end else begin
                    head_d = '0;
                    tail_d = '0;
                  end
                end
              end
              default: res.data.status = STAT_OK;
            endcase
          end
        end
      end
      ST_DRAIN: begin
        if (out_free_i) begin
          res.valid          = 1'b1;
          res.data.outcome   = OUT_RELEASED;
          res.data.thread_id = ram_rdata;
          res.data.last      = !drain_more;
          fill_d             = fill_q - 1'b1;
          if (drain_more) begin
            head_d    = head_nx;
            ram_re    = 1'b1;
            ram_raddr = head_nx;
          end else begin
            head_d = '0;
            tail_d = '0;
          end
        end
      end
      default: ;
    endcase

    // register write reinitialises the semaphore
    if (cfg_we_i) begin
      count_d = COUNT_W'(cfg_wdata_i);
      open_d  = 1'b1;
      head_d  = '0;
      tail_d  = '0;
      fill_d  = '0;
    end
  end

  assign res_o = res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      count_q <= '0;
      open_q  <= 1'b1;
      head_q  <= '0;
      tail_q  <= '0;
      fill_q  <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      open_q  <= open_d;
      head_q  <= head_d;
      tail_q  <= tail_d;
      fill_q  <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    action_q <= action_d;
    caller_q <= caller_d;
  end

  `CSQ_ASSERT(a_fill_bound, fill_q <= FULL_FILL)
  `CSQ_ASSERT_IMP(a_drain_closed, state_q == ST_DRAIN, !open_q && fill_q != '0)
  `CSQ_ASSERT_IMP(a_res_has_room, res.valid, out_free_i)
  `CSQ_ASSERT_NXT(a_one_at_a_time, in_valid_i && in_ready_o, !in_ready_o)

endmodule

FILE: rtl/counting_semaphore_wait_queue.sv
// Counting semaphore with a FIFO wait queue of blocked thread ids. For wait
// and signal requests the accept cycle reads the head of the queue ram and
// the exec state then decides, updates the count and pointers and writes the
// caller at the tail if it blocks. A close releases one waiter per cycle
// while the output register is free, as the ram is read ahead one entry at
// a time. Results sit in an output register, so a new request is taken
// while a result waits, but the block stalls in its decision cycle until
// that register is free. Writing initial_count reloads the count, reopens
// the semaphore and empties the queue at once; there is no clearing pass
// after reset.
`include "assert_macros.svh"

module counting_semaphore_wait_queue #(
  parameter int unsigned QUEUE_DEPTH = csq_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  csq_pkg::csq_in_t          in_data_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output csq_pkg::csq_out_t         out_data_o,
  input  logic                      cfg_we_i,
  input  logic [csq_pkg::CFG_W-1:0] cfg_wdata_i
);
  import csq_pkg::*;

  logic     out_valid_q, out_valid_d;
  csq_out_t out_data_q, out_data_d;
  logic     out_free;
  csq_res_t res;

  assign out_free = !out_valid_q || out_ready_i;

  csq_core #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_free_i (out_free),
    .res_o      (res),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    if (res.valid) begin
      out_valid_d = 1'b1;
      out_data_d  = res.data;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // a new result only lands once the previous transaction has gone
  `CSQ_ASSERT_NXT(a_load_shows, res.valid, out_valid_o)
  `CSQ_ASSERT_IMP(a_no_overwrite, out_valid_q && !out_ready_i, !res.valid)

endmodule

FILE: tb/tb_top.sv
// testbench for the counting semaphore wait queue: stimulus, prediction and checking
module tb_top;
  import csq_pkg::*;

  localparam logic [1:0] ACT_UNUSED = 2'd3;
  localparam int unsigned LIMIT = 1_000_000;
  localparam int unsigned SETTLE = 4;

  // predicts the replies of the semaphore and checks them in order
  class sem_scoreboard;
    int unsigned errors;
    csq_out_t replies_due[$];
    int count;
    bit is_open;
    logic [TID_W-1:0] waiters[$];

    function new();
      errors = 0;
      reload(0);
    endfunction

    function void reload(int unsigned init_val);
      count = init_val;
      is_open = 1'b1;
      waiters.delete();
    endfunction

    function int unsigned pending();
      return replies_due.size();
    endfunction

    function void add_reply(logic [1:0] st, logic [1:0] oc, logic [TID_W-1:0] tid,
                            logic lst);
      csq_out_t r;
      r.status = st;
      r.outcome = oc;
      r.thread_id = tid;
      r.last = lst;
      replies_due.push_back(r);
    endfunction

    function void note_request(csq_in_t req);
      logic [TID_W-1:0] tid;
      if (req.action == ACT_UNUSED) begin
        add_reply(STAT_OK, OUT_PROCEED, '0, 1'b1);
      end else if (!is_open) begin
        add_reply(STAT_CLOSED, OUT_PROCEED, '0, 1'b1);
      end else if (req.action == ACT_WAIT) begin
        if (count - 1 < 0) begin
          if (waiters.size() >= QUEUE_DEPTH_DEF) begin
            add_reply(STAT_FULL, OUT_PROCEED, '0, 1'b1);
          end else begin
            count--;
            waiters.push_back(req.caller_id);
            add_reply(STAT_OK, OUT_BLOCKED, req.caller_id, 1'b1);
          end
        end else begin
          count--;
          add_reply(STAT_OK, OUT_PROCEED, '0, 1'b1);
        end
      end else if (req.action == ACT_SIGNAL) begin
        if (count >= int'(COUNT_MAX)) begin
          count = int'(COUNT_MAX);
          add_reply(STAT_OK, OUT_PROCEED, '0, 1'b1);
        end else begin
          count++;
          if (count <= 0 && waiters.size() > 0) begin
            tid = waiters.pop_front();
            add_reply(STAT_OK, OUT_RELEASED, tid, 1'b1);
          end else begin
            add_reply(STAT_OK, OUT_PROCEED, '0, 1'b1);
          end
        end
      end else begin
        is_open = 1'b0;
        if (waiters.size() == 0) begin
          add_reply(STAT_OK, OUT_PROCEED, '0, 1'b1);
        end
        // every waiter goes out in arrival order, last flag on the final one
        while (waiters.size() > 0) begin
          tid = waiters.pop_front();
          add_reply(STAT_OK, OUT_RELEASED, tid, waiters.size() == 0);
        end
      end
    endfunction

    task report(string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      errors++;
    endtask

    task check_reply(csq_out_t got);
      csq_out_t exp;
      if (replies_due.size() == 0) begin
        report($sformatf("unexpected transaction %p", got));
      end else begin
        exp = replies_due.pop_front();
        if (got.status !== exp.status)
          report($sformatf("status %0d, expected %0d", got.status, exp.status));
        if (got.outcome !== exp.outcome)
          report($sformatf("outcome %0d, expected %0d", got.outcome, exp.outcome));
        if (got.thread_id !== exp.thread_id)
          report($sformatf("thread_id %0h, expected %0h", got.thread_id, exp.thread_id));
        if (got.last !== exp.last)
          report($sformatf("last %0d, expected %0d", got.last, exp.last));
      end
    endtask
  endclass

  logic clk_i;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  csq_in_t in_data_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  csq_out_t out_data_o;
  logic cfg_we_i = 1'b0;
  logic [CFG_W-1:0] cfg_wdata_i = '0;

  sem_scoreboard sb = new();
  bit idle_on = 1'b1;
  bit hold_req = 1'b0;
  int unsigned cycle_cnt = 0;

  counting_semaphore_wait_queue dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) cycle_cnt <= cycle_cnt + 1;

  initial begin : watchdog
    wait (cycle_cnt >= LIMIT);
    $display("** counting_semaphore_wait_queue: FAILED **");
    $finish;
  end

  // result side: checks each transaction and paces ready
  initial begin : receiver
    int unsigned stall_left;
    int unsigned hold_left;
    stall_left = 0;
    hold_left = 0;
    forever begin
      @(posedge clk_i);
      if (out_valid_o === 1'b1 && out_ready_i) sb.check_reply(out_data_o);
      if (hold_req) begin
        hold_req = 1'b0;
        hold_left = 80;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ready_i <= 1'b0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(0, 2);
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // valid is left high afterwards until the next send or wait_idle drives it again
  task automatic send(input logic [1:0] act, input logic [TID_W-1:0] id);
    csq_in_t req;
    int unsigned gap;
    req.action = act;
    req.caller_id = id;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 3);
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= req;
    do @(posedge clk_i); while (in_ready_o !== 1'b1);
    sb.note_request(req);
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_init(input int unsigned val);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= val[CFG_W-1:0];
    @(posedge clk_i);
    sb.reload(32'(val[CFG_W-1:0]));
    cfg_we_i <= 1'b0;
  endtask

  task automatic run_phase(input int unsigned init_val, input int unsigned n,
                           input int unsigned wait_pct, input bit pressure,
                           input bit close_at_end);
    int unsigned r;
    wait_idle();
    write_init(init_val);
    if (pressure) hold_req = 1'b1;
    repeat (n) begin
      r = $urandom_range(0, 99);
      if (r < wait_pct) send(ACT_WAIT, 8'($urandom));
      else if (r < 95) send(ACT_SIGNAL, 8'($urandom));
      else if (r < 98) send(ACT_UNUSED, 8'($urandom));
      else send(ACT_CLOSE, 8'($urandom));
    end
    if (close_at_end) begin
      send(ACT_CLOSE, 8'($urandom));
      send(ACT_WAIT, 8'($urandom));
      send(ACT_SIGNAL, 8'($urandom));
    end
  endtask

  initial begin : stimulus
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // count starts at zero from reset
    send(ACT_SIGNAL, 8'h00);
    send(ACT_WAIT, 8'h3c);
    send(ACT_WAIT, 8'h00);
    send(ACT_WAIT, 8'hff);
    send(ACT_SIGNAL, 8'hc3);
    send(ACT_UNUSED, 8'h81);
    // fill the wait queue, then one wait too many
    for (int i = 0; i < 15; i++) send(ACT_WAIT, 8'(i * 17 + 1));
    send(ACT_WAIT, 8'ha5);
    send(ACT_CLOSE, 8'h7e);
    // everything on a closed semaphore
    send(ACT_WAIT, 8'h5a);
    send(ACT_SIGNAL, 8'hff);
    send(ACT_CLOSE, 8'h00);
    send(ACT_UNUSED, 8'hff);
    wait_idle();
    write_init(0);
    send(ACT_CLOSE, 8'h18);
    send(ACT_SIGNAL, 8'he7);

    run_phase(2, 40, 70, 1'b0, 1'b1);
    run_phase(0, 45, 75, 1'b1, 1'b1);
    run_phase(1, 35, 55, 1'b0, 1'b0);
    run_phase($urandom_range(0, 6), 30, 65, 1'b0, 1'b1);
    run_phase($urandom_range(0, 65535), 25, 60, 1'b0, 1'b0);
    run_phase(65535, 20, 50, 1'b0, 1'b1);

    // no idling from here on
    idle_on = 1'b0;
    run_phase(3, 25, 65, 1'b0, 1'b1);
    wait_idle();

    if (sb.errors == 0) begin
      $display("** counting_semaphore_wait_queue: PASSED **");
    end else begin
      $display("** counting_semaphore_wait_queue: FAILED **");
    end
    $finish;
  end

endmodule
